### design/bmhq_pkg.sv
// shared types and codes for the binary min-heap queue
package bmhq_pkg;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req;

    typedef struct packed {
        logic               is_pop;
        logic signed [31:0] key;
        logic        [31:0] payload;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_WR,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD0,
        S_POP_RDL,
        S_POP_WR0,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_REPLY
    } t_state;

endpackage

### design/bmhq_front.sv
// front end: request capture into a small command queue
module bmhq_front
    import bmhq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_cmd               i_cmd,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output t_cmd               o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_q[r_rp];

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("queue underflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("bad count");

endmodule

### design/bmhq_back.sv
// back end: heap memory and sift sequencer
module bmhq_back
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int AW = 10,
    parameter int CW = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_cmd               i_cmd,
    output logic               o_take,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_min_key,
    output logic [31:0]        o_min_payload,
    output logic [10:0]        o_fill_count
);

    localparam logic [CW-1:0] CapC = CW'(CAPACITY);

    logic [63:0] r_mem [CAPACITY];
    logic [63:0] r_rd;
    logic [AW-1:0] rd_addr, wr_addr;
    logic rd_en, wr_en;
    logic [63:0] wr_data;

    t_state r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_pick, n_pick;
    logic [63:0] r_cur, n_cur;
    logic [63:0] r_oth, n_oth;
    logic [1:0] r_stat, n_stat;
    logic [63:0] r_out, n_out;
    logic has_r;
    logic [CW:0] lc_w;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= r_mem[rd_addr];
    end

    function automatic logic lt(input logic [63:0] a, input logic [63:0] b);
        return $signed(a[63:32]) < $signed(b[63:32]);
    endfunction

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_pos = r_pos; n_pick = r_pick;
        n_cur = r_cur; n_oth = r_oth; n_stat = r_stat; n_out = r_out;
        rd_en = 1'b0; rd_addr = r_pos; wr_en = 1'b0; wr_addr = r_pos;
        wr_data = r_cur; o_take = 1'b0; o_done = 1'b0;
        lc_w = {r_pos, 1'b1} + (CW+1)'(0);
        has_r = (lc_w + 1'b1) < {1'b0, r_cnt};
        unique case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    o_take = 1'b1;
                    n_out  = '0;
                    n_stat = ST_DONE;
                    n_cur  = {i_cmd.key, i_cmd.payload};
                    if (!i_cmd.is_pop) begin
                        if (r_cnt >= CapC) begin
                            n_stat = ST_FULL; n_st = S_REPLY;
                        end else begin
                            n_pos = r_cnt[AW-1:0]; n_st = S_PUSH_WR;
                        end
                    end else if (r_cnt == '0) begin
                        n_stat = ST_EMPTY; n_st = S_REPLY;
                    end else begin
                        n_st = S_POP_RD0;
                    end
                end
            end
            S_PUSH_WR: begin
                wr_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_pos == '0) n_st = S_REPLY;
                else begin
                    rd_en = 1'b1; rd_addr = (r_pos - 1'b1) >> 1;
                    n_pick = rd_addr; n_st = S_UP_CMP;
                end
            end
            S_UP_RD: begin
                wr_en = 1'b1;
                if (r_pos == '0) n_st = S_REPLY;
                else begin
                    rd_en = 1'b1; rd_addr = (r_pos - 1'b1) >> 1;
                    n_pick = rd_addr; n_st = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (lt(r_cur, r_rd)) begin
                    wr_en = 1'b1; wr_addr = r_pos; wr_data = r_rd;
                    n_pos = r_pick; n_st = S_UP_RD;
                end else n_st = S_REPLY;
            end
            S_POP_RD0: begin
                rd_en = 1'b1; rd_addr = '0; n_st = S_POP_RDL;
            end
            S_POP_RDL: begin
                n_out = r_rd;
                n_cnt = r_cnt - 1'b1;
                rd_en = 1'b1; rd_addr = n_cnt[AW-1:0];
                n_pos = '0;
                n_st = (n_cnt == '0) ? S_REPLY : S_POP_WR0;
            end
            S_POP_WR0: begin
                n_cur = r_rd;
                n_st = S_DN_RDL;
            end
            S_DN_RDL: begin
                if ({1'b0, r_pos} < (r_cnt >> 1)) begin
                    rd_en = 1'b1; rd_addr = lc_w[AW-1:0]; n_st = S_DN_RDR;
                end else begin
                    wr_en = 1'b1; n_st = S_REPLY;
                end
            end
            S_DN_RDR: begin
                n_oth = r_rd; n_pick = lc_w[AW-1:0];
                if (has_r) begin
                    rd_en = 1'b1; rd_addr = lc_w[AW-1:0] + 1'b1;
                end
                n_st = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (has_r && lt(r_rd, r_oth)) begin
                    n_oth = r_rd; n_pick = r_pick + 1'b1;
                end
                if (lt(n_oth, r_cur)) begin
                    wr_en = 1'b1; wr_addr = r_pos; wr_data = n_oth;
                    n_pos = n_pick; n_st = S_DN_RDL;
                end else begin
                    wr_en = 1'b1; n_st = S_REPLY;
                end
            end
            S_REPLY: begin
                o_done = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt;
        end
        r_pos <= n_pos; r_pick <= n_pick; r_cur <= n_cur; r_oth <= n_oth;
        r_stat <= n_stat; r_out <= n_out;
    end

    assign o_status      = r_stat;
    assign o_min_key     = r_out[63:32];
    assign o_min_payload = r_out[31:0];
    assign o_fill_count  = 11'(r_cnt);

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CapC) else $error("count above capacity");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> r_st == S_IDLE) else $error("take outside idle");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double reply");

endmodule

### design/binary_min_heap_queue_unit.sv
// top level of the binary min-heap priority queue
// usage: raise start with req_type, key and payload while busy is low;
// the item is taken at that edge. req_type 0 pushes (key, payload),
// 1 pops the entry with the smallest signed key (ties keep heap order).
// one result per item appears for a single cycle with o_valid high:
// status, min_key, min_payload and fill_count after the item.
// a push sifts up one level per parent read and compare-and-move step,
// a pop sifts down one level per two child reads and a compare, all
// through the heap memory with one read port and one write port; items
// are served one at a time. a two-entry command queue in front lets busy
// stay low while the heap engine works on the previous item.
// reset empties the queue; memory contents are not cleared and are read
// only after being written. the receiver cannot stall results.
module binary_min_heap_queue_unit
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic signed [31:0] i_key,
    input  logic [31:0]        i_payload,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_min_key,
    output logic [31:0]        o_min_payload,
    output logic [10:0]        o_fill_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    t_cmd in_cmd, q_cmd;
    logic q_full, q_valid, take;

    assign in_cmd = '{is_pop: (i_req_type == REQ_POP), key: i_key, payload: i_payload};
    assign busy   = q_full;

    bmhq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(start && !busy), .i_cmd(in_cmd), .i_pop(take),
        .o_full(q_full), .o_valid(q_valid), .o_cmd(q_cmd)
    );

    bmhq_back #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .i_cmd(q_cmd), .o_take(take),
        .o_done(o_valid), .o_status(o_status), .o_min_key(o_min_key),
        .o_min_payload(o_min_payload), .o_fill_count(o_fill_count)
    );

endmodule

### tb/binary_min_heap_queue_unit_tb.sv
// testbench for the binary min-heap priority queue: heap predictor and result checks
`timescale 1ns / 1ps

module binary_min_heap_queue_unit_tb;
    import bmhq_pkg::*;

    localparam int CAP = 1024;

    class heap_scoreboard;
        logic signed [31:0] hkey[CAP];
        logic [31:0]        hpay[CAP];
        int                 count;
        t_status            q_status[$];
        logic signed [31:0] q_key[$];
        logic [31:0]        q_pay[$];
        logic [10:0]        q_fill[$];
        int                 errors;

        function void clear();
            count = 0;
            errors = 0;
        endfunction

        function void swap_entries(int a, int b);
            logic signed [31:0] k;
            logic [31:0] p;
            k = hkey[a]; hkey[a] = hkey[b]; hkey[b] = k;
            p = hpay[a]; hpay[a] = hpay[b]; hpay[b] = p;
        endfunction

        function void note_item(t_req req, logic signed [31:0] key, logic [31:0] pay);
            t_status st;
            logic signed [31:0] ok;
            logic [31:0] op;
            int pos;
            int up;
            int lc;
            int pick;
            st = ST_DONE;
            ok = '0;
            op = '0;
            if (req == REQ_PUSH) begin
                if (count >= CAP) begin
                    st = ST_FULL;
                end else begin
                    hkey[count] = key;
                    hpay[count] = pay;
                    pos = count;
                    while (pos > 0) begin
                        up = (pos - 1) / 2;
                        if (hkey[pos] >= hkey[up]) break;
                        swap_entries(pos, up);
                        pos = up;
                    end
                    count++;
                end
            end else begin
                if (count == 0) begin
                    st = ST_EMPTY;
                end else begin
                    ok = hkey[0];
                    op = hpay[0];
                    count--;
                    if (count > 0) begin
                        hkey[0] = hkey[count];
                        hpay[0] = hpay[count];
                        pos = 0;
                        while (pos < count / 2) begin
                            lc = 2 * pos + 1;
                            pick = lc;
                            if (lc + 1 < count && hkey[lc] > hkey[lc + 1]) pick = lc + 1;
                            if (hkey[pos] <= hkey[pick]) break;
                            swap_entries(pos, pick);
                            pos = pick;
                        end
                    end
                end
            end
            q_status.push_back(st);
            q_key.push_back(ok);
            q_pay.push_back(op);
            q_fill.push_back(count[10:0]);
        endfunction

        function void check_result(logic [1:0] st, logic signed [31:0] k, logic [31:0] p,
                                   logic [10:0] f);
            if (q_status.size() == 0) begin
                $error("result with no item pending");
                errors++;
                return;
            end
            if (st !== q_status[0]) begin
                $error("status expected %0d actual %0d", q_status[0], st);
                errors++;
            end
            if (k !== q_key[0]) begin
                $error("min_key expected %0d actual %0d", q_key[0], k);
                errors++;
            end
            if (p !== q_pay[0]) begin
                $error("min_payload expected %h actual %h", q_pay[0], p);
                errors++;
            end
            if (f !== q_fill[0]) begin
                $error("fill_count expected %0d actual %0d", q_fill[0], f);
                errors++;
            end
            void'(q_status.pop_front());
            void'(q_key.pop_front());
            void'(q_pay.pop_front());
            void'(q_fill.pop_front());
        endfunction

        function int pending();
            return q_status.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_req_type = 1'b0;
    logic signed [31:0] i_key = '0;
    logic [31:0]        i_payload = '0;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_min_key;
    logic [31:0]        o_min_payload;
    logic [10:0]        o_fill_count;

    heap_scoreboard heap_sb;
    bit             idling = 1'b1;

    binary_min_heap_queue_unit #(.CAPACITY(CAP)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_key(i_key), .i_payload(i_payload),
        .o_valid(o_valid), .o_status(o_status), .o_min_key(o_min_key),
        .o_min_payload(o_min_payload), .o_fill_count(o_fill_count)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            heap_sb.check_result(o_status, o_min_key, o_min_payload, o_fill_count);
        end
    end

    task automatic send_item(t_req req, logic signed [31:0] key, logic [31:0] pay);
        int gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= req;
        i_key <= key;
        i_payload <= pay;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        heap_sb.note_item(req, key, pay);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (heap_sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_key(int span);
        if (span == 0) return $urandom();
        return $urandom_range(0, span) - span / 2;
    endfunction

    initial begin
        int n;
        int j;
        int phase_len;
        bit pushing;
        heap_sb = new();
        heap_sb.clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(REQ_POP, '0, '0);
        send_item(REQ_PUSH, 32'sh7fffffff, 32'hffffffff);
        send_item(REQ_PUSH, 32'sh80000000, 32'h00000000);
        send_item(REQ_PUSH, 32'sd0, 32'haaaaaaaa);
        send_item(REQ_PUSH, 32'sd0, 32'h55555555);
        send_item(REQ_PUSH, -32'sd1, 32'h1);
        send_item(REQ_PUSH, 32'sd1, 32'h2);
        send_item(REQ_POP, 32'sh7fffffff, 32'hffffffff);
        for (j = 0; j < 6; j++) send_item(REQ_POP, '0, '0);
        send_item(REQ_POP, '0, '0);
        wait_drained();

        // fill to capacity and overflow
        for (j = 0; j < CAP + 3; j++) send_item(REQ_PUSH, pick_key(j % 3 == 0 ? 40 : 0), $urandom());
        wait_drained();

        n = 0;
        while (n < 950) begin
            phase_len = $urandom_range(5, 60);
            pushing = $urandom_range(0, 1);
            if (n > 800) idling = 1'b0;
            for (j = 0; j < phase_len; j++) begin
                if ($urandom_range(0, 3) == 0) pushing = !pushing;
                if (pushing || $urandom_range(0, 2) == 0)
                    send_item(REQ_PUSH, pick_key($urandom_range(0, 1) ? 16 : 0), $urandom());
                else
                    send_item(REQ_POP, $urandom(), $urandom());
                n++;
            end
        end
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (heap_sb.errors == 0 && heap_sb.pending() == 0) begin
            $display("binary_min_heap_queue_unit verification clean");
        end else begin
            $display("binary_min_heap_queue_unit verification failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("binary_min_heap_queue_unit verification failed");
        $finish;
    end
endmodule

### binary_min_heap_queue_unit.f
design/bmhq_pkg.sv
design/bmhq_front.sv
design/bmhq_back.sv
design/binary_min_heap_queue_unit.sv
tb/binary_min_heap_queue_unit_tb.sv
